@@ hdl/packed_normal_normalizer_assert.svh @@
// assertion macros for the packed normal normalizer
`ifndef PACKED_NORMAL_NORMALIZER_ASSERT_SVH
`define PACKED_NORMAL_NORMALIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PNN_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PNN_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PNN_ASSERT(lbl, clk, rstn, prop, msg)
`define PNN_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

@@ hdl/pnn_pkg.sv @@
// shared constants and types for the packed normal normalizer
`default_nettype none
package pnn_pkg;
  localparam int FRAC_BITS = 14;
  localparam int QW = FRAC_BITS + 1;
  localparam int RW = 2 * FRAC_BITS + 22;
  localparam int BW = FRAC_BITS + 19;
  localparam int IW = $clog2(FRAC_BITS + 1);
  localparam int XW = (QW > 16) ? QW : 16;
  localparam int NSTEP = FRAC_BITS + 1;
  localparam logic [15:0] NORM_ONE = 16'(64'(1) << FRAC_BITS);

  typedef struct packed {
    logic [QW-1:0]        q;
    logic signed [RW-1:0] rm;
    logic signed [BW-1:0] b;
    logic [15:0]          s;
  } lane_st_t;
endpackage
`default_nettype wire

@@ hdl/pnn_step.sv @@
// one bit decision of the square root ratio search
`default_nettype none
module pnn_step (
  input  wire pnn_pkg::lane_st_t       st_i,
  input  wire logic [pnn_pkg::IW-1:0]  idx_i,
  output pnn_pkg::lane_st_t            st_o
);
  logic [pnn_pkg::IW:0]                sh1, sh2;
  logic signed [pnn_pkg::RW-1:0]       bx, sx, rm_t;
  logic                                ok;

  // setting bit i: (2q-1)^2 s grows by (2q-1)s * 2^(i+2) plus s * 4^(i+1)
  always_comb begin
    sh1  = {1'b0, idx_i} + 1'b1;
    sh2  = {idx_i, 1'b0} + 2'd2;
    bx   = pnn_pkg::RW'(st_i.b);
    sx   = $signed(pnn_pkg::RW'(st_i.s));
    rm_t = st_i.rm - (bx <<< (sh1 + 1'b1)) - (sx <<< sh2);
    ok   = !rm_t[pnn_pkg::RW-1] &&
           ((idx_i == pnn_pkg::IW'(pnn_pkg::FRAC_BITS)) || !st_i.q[pnn_pkg::FRAC_BITS]);
    st_o = st_i;
    if (ok) begin
      st_o.q  = st_i.q | (pnn_pkg::QW'(1) << idx_i);
      st_o.rm = rm_t;
      st_o.b  = st_i.b + ($signed(pnn_pkg::BW'(st_i.s)) <<< sh1);
    end
  end
endmodule
`default_nettype wire

@@ hdl/pnn_lane.sv @@
// one lane: pipelined bit-by-bit search for round(mag * 2^f / sqrt(s))
`default_nettype none
module pnn_lane (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [7:0]                mag_i,
  input  wire logic [15:0]               s_i,
  output logic [pnn_pkg::QW-1:0]         q_o
);
  pnn_pkg::lane_st_t st_in [pnn_pkg::NSTEP];
  pnn_pkg::lane_st_t st_nx [pnn_pkg::NSTEP];
  pnn_pkg::lane_st_t st_q  [pnn_pkg::NSTEP];
  pnn_pkg::lane_st_t st_first;
  logic [14:0] c2;

  // start at q = 0 (d = -1): remainder = 4c^2 * 4^f - s, b = -s
  always_comb begin
    c2 = 15'(16'(mag_i) * 16'(mag_i));
    st_first.q  = '0;
    st_first.rm = $signed(pnn_pkg::RW'(c2) << (2 * pnn_pkg::FRAC_BITS + 2))
                  - $signed(pnn_pkg::RW'(s_i));
    st_first.b  = -$signed(pnn_pkg::BW'(s_i));
    st_first.s  = s_i;
  end

  for (genvar k = 0; k < pnn_pkg::NSTEP; k++) begin : g_step
    if (k > 0) begin : g_link
      assign st_in[k] = st_q[k-1];
    end else begin : g_first
      assign st_in[k] = st_first;
    end
    pnn_step u_step (
      .st_i  (st_in[k]),
      .idx_i (pnn_pkg::IW'(pnn_pkg::FRAC_BITS - k)),
      .st_o  (st_nx[k])
    );
    always_ff @(posedge clk_i) begin
      if (en_i) st_q[k] <= st_nx[k];
    end
  end

  assign q_o = st_q[pnn_pkg::NSTEP-1].q;
endmodule
`default_nettype wire

@@ hdl/packed_normal_normalizer.sv @@
// top level: three search lanes plus sign and zero-vector merge
// from accept to result an item passes the front register, the search stages and the output register
// throughput: one item per cycle; each search bit is its own pipeline stage
// the whole pipe advances together and holds while a result waits under stall_i
// reset (rst_ni low, asynchronous) empties every stage; payload is not cleared
`default_nettype none
`include "packed_normal_normalizer_assert.svh"
module packed_normal_normalizer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    stall_o,
  input  wire logic signed [7:0]  comp_x_i,
  input  wire logic signed [7:0]  comp_y_i,
  input  wire logic signed [7:0]  comp_z_i,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output logic signed [15:0]      norm_x_o,
  output logic signed [15:0]      norm_y_o,
  output logic signed [15:0]      norm_z_o,
  output logic                    zero_input_o
);
  localparam int NSTG = pnn_pkg::NSTEP + 1;

  logic                en;
  logic [NSTG-1:0]     vld_q;
  logic [2:0]          neg_q [NSTG];
  logic                zro_q [NSTG];
  logic [7:0]          mag_q [3];
  logic [15:0]         s_q;
  logic [7:0]          mag_d [3];
  logic [15:0]         s_d;
  logic [2:0]          neg_d;
  logic [pnn_pkg::QW-1:0] q_lane [3];
  logic signed [15:0]  res_d [3];
  logic [pnn_pkg::XW-1:0] qx;
  logic                out_vld_q;

  // whole pipe moves when the output slot is free or being taken
  assign en      = !out_vld_q || !stall_i;
  assign stall_o = !en;

  // front: magnitudes and sum of squares
  always_comb begin
    neg_d = {comp_z_i[7], comp_y_i[7], comp_x_i[7]};
    mag_d[0] = comp_x_i[7] ? 8'(-comp_x_i) : comp_x_i;
    mag_d[1] = comp_y_i[7] ? 8'(-comp_y_i) : comp_y_i;
    mag_d[2] = comp_z_i[7] ? 8'(-comp_z_i) : comp_z_i;
    s_d = 16'(mag_d[0]) * 16'(mag_d[0]) + 16'(mag_d[1]) * 16'(mag_d[1])
          + 16'(mag_d[2]) * 16'(mag_d[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NSTG-2:0], valid_i};
      out_vld_q <= vld_q[NSTG-1];
    end
  end

  // side info rides along with the lanes
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q    <= mag_d;
      s_q      <= s_d;
      neg_q[0] <= neg_d;
      zro_q[0] <= (s_d == '0);
      for (int i = 1; i < NSTG; i++) begin
        neg_q[i] <= neg_q[i-1];
        zro_q[i] <= zro_q[i-1];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    pnn_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .mag_i (mag_q[l]),
      .s_i   (s_q),
      .q_o   (q_lane[l])
    );
  end

  // merge: apply signs, substitute (0,0,1) for the zero vector
  always_comb begin
    qx = '0;
    for (int l = 0; l < 3; l++) begin
      qx = pnn_pkg::XW'(q_lane[l]);
      res_d[l] = neg_q[NSTG-1][l] ? 16'(-qx) : 16'(qx);
    end
    if (zro_q[NSTG-1]) begin
      res_d[0] = '0;
      res_d[1] = '0;
      res_d[2] = pnn_pkg::NORM_ONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      norm_x_o     <= res_d[0];
      norm_y_o     <= res_d[1];
      norm_z_o     <= res_d[2];
      zero_input_o <= zro_q[NSTG-1];
    end
  end

  assign valid_o = out_vld_q;

  `PNN_ASSERT(a_zero_fallback, clk_i, rst_ni, valid_o && zero_input_o |-> norm_x_o == '0 && norm_y_o == '0 && norm_z_o == pnn_pkg::NORM_ONE, "zero vector fallback wrong")
  `PNN_ASSERT(a_stall_src, clk_i, rst_ni, stall_o == (valid_o && stall_i), "stall_o not tied to output slot")
  `PNN_ASSERT(a_hold, clk_i, rst_ni, valid_o && stall_i |=> valid_o && $stable(norm_x_o) && $stable(zero_input_o), "held result lost")
endmodule
`default_nettype wire

@@ dv/packed_normal_normalizer_test.sv @@
// testbench for the packed normal normalizer: directed and random vectors checked per item
`timescale 1ns / 1ps
module packed_normal_normalizer_test;

  localparam int LIMIT_CYCLES = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic signed [7:0] comp_x_i = '0;
  logic signed [7:0] comp_y_i = '0;
  logic signed [7:0] comp_z_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic signed [15:0] norm_x_o, norm_y_o, norm_z_o;
  logic zero_input_o;

  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        zero;
  } unit_vec_t;

  unit_vec_t pending_units[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  packed_normal_normalizer dut (.*);

  // free-running clock, 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog on the cycle count
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stalls at random, at the configured rate
  always @(posedge clk_i) begin
    stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // rounded magnitude of mag * 2^F / sqrt(sumsq), ties away from zero
  // largest q with (2q-1)^2 * sumsq <= 4 mag^2 4^F, found by bisection
  function automatic logic [63:0] rounded_unit_mag(int unsigned mag, int unsigned sumsq);
    logic [127:0] lhs, rhs;
    logic [63:0] lo, hi, mid;
    rhs = (128'(4) * mag * mag) << (2 * pnn_pkg::FRAC_BITS);
    lo = 0;
    hi = 64'(1) << pnn_pkg::FRAC_BITS;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      lhs = 128'(2 * mid - 1) * 128'(2 * mid - 1) * sumsq;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic unit_vec_t predict_unit(logic signed [7:0] x, logic signed [7:0] y,
                                             logic signed [7:0] z);
    unit_vec_t u;
    int unsigned mx, my, mz, sumsq;
    mx = (x < 0) ? -int'(x) : int'(x);
    my = (y < 0) ? -int'(y) : int'(y);
    mz = (z < 0) ? -int'(z) : int'(z);
    sumsq = mx * mx + my * my + mz * mz;
    if (sumsq == 0) begin
      u.nx = '0;
      u.ny = '0;
      u.nz = pnn_pkg::NORM_ONE;
      u.zero = 1'b1;
    end else begin
      // magnitude rounded first, sign applied after; wrap to 16 bits
      u.nx = 16'(rounded_unit_mag(mx, sumsq));
      u.ny = 16'(rounded_unit_mag(my, sumsq));
      u.nz = 16'(rounded_unit_mag(mz, sumsq));
      if (x < 0) u.nx = -u.nx;
      if (y < 0) u.ny = -u.ny;
      if (z < 0) u.nz = -u.nz;
      u.zero = 1'b0;
    end
    return u;
  endfunction

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", field, got, want, cycle_count);
    mismatch_count++;
  endtask

  // compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin
    unit_vec_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_units.size() == 0) begin
        report_mismatch("unexpected item", 16'(norm_x_o), 16'h0);
      end else begin
        want = pending_units.pop_front();
        if (norm_x_o !== want.nx) report_mismatch("norm_x", norm_x_o, want.nx);
        if (norm_y_o !== want.ny) report_mismatch("norm_y", norm_y_o, want.ny);
        if (norm_z_o !== want.nz) report_mismatch("norm_z", norm_z_o, want.nz);
        if (zero_input_o !== want.zero)
          report_mismatch("zero_input", 16'(zero_input_o), 16'(want.zero));
      end
    end
  end

  // send one item; valid held until accepted, prediction queued on accept
  // valid drops only when the sender idles, so back to back items keep it high
  task automatic send_vector(logic signed [7:0] x, logic signed [7:0] y, logic signed [7:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    comp_x_i <= x;
    comp_y_i <= y;
    comp_z_i <= z;
    do @(posedge clk_i); while (stall_o);
    pending_units.insert(pending_units.size(), predict_unit(x, y, z));
  endtask

  task automatic drain_results();
    valid_i <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk_i);
  endtask

  // extremes, axes, zero vector and minus 128
  task automatic test_directed();
    send_vector(0, 0, 0);
    send_vector(127, 0, 0);
    send_vector(0, -128, 0);
    send_vector(0, 0, -128);
    send_vector(-128, -128, -128);
    send_vector(127, 127, 127);
    send_vector(-128, 127, -128);
    send_vector(1, 0, 0);
    send_vector(-1, -1, -1);
    send_vector(3, 4, 0);
    send_vector(-3, 0, 4);
    send_vector(1, 1, 0);
    send_vector(2, 3, 6);
    send_vector(-85, 42, 1);
    send_vector(0, 0, 0);
    send_vector(8'h55, 8'hAA, 8'h7F);
  endtask

  task automatic test_random(int count);
    int k;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0: send_vector(0, 0, 0);
        1: send_vector(8'($urandom_range(3) - 2), 8'($urandom_range(3) - 2),
                       8'($urandom_range(3) - 2));
        2: send_vector(-128, 8'($urandom), 8'($urandom));
        default: send_vector(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  // sender waits for the pipe to empty, then sends a burst into an idle block
  task automatic test_drained_restart();
    drain_results();
    test_random(20);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 22;
    recv_idle_pct = 85;
    test_directed();
    test_random(260);
    test_drained_restart();

    send_idle_pct = 85;
    recv_idle_pct = 22;
    test_random(260);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(270);

    drain_results();
    repeat (pnn_pkg::FRAC_BITS + 10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_units.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
